// ===== sv/tmf_pkg.sv =====
// ============================================================================
// tmf_pkg: shared types and constants of the trimmed mean filter
// Holds the sequencer state type, the fixed port widths, the number of
// samples that survive trimming and the extra width of their sum.
// ============================================================================
`default_nettype none

package tmf_pkg;

  // Fixed widths of the request and result fields.
  localparam int CH_BITS     = 3;
  localparam int SAMPLE_IN_W = 10;
  localparam int OUT_BITS    = 10;

  // Number of middle samples that are kept and averaged.
  localparam int KEEP_COUNT  = 3;

  // Extra bits the sum of the kept samples needs over one sample.
  localparam int SUM_GROWTH  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK
  } tmf_state_t;

endpackage

`default_nettype wire

// ===== sv/trimmed_mean_of_five_filter.sv =====
// ============================================================================
// trimmed_mean_of_five_filter: per-channel trimmed mean of a group of samples
// Collects samples per channel and, on each completed group, gives the
// truncated mean of the middle three samples in sorted order.
// ============================================================================
// A request that does not complete its channel's group leaves busy low, so
// such requests may come in every cycle while busy is low.
// A request that completes a group holds busy high for the load-and-rank
// pass; the done strobe comes in the first cycle with busy low again.
// The length of the pass is set by the single comparator, which visits
// every ordered pair of the group, after a memory load.
// Reset clears the fill counts and the sequencer; done is never held off.
`default_nettype none

module trimmed_mean_of_five_filter #(
  parameter int CHANNELS    = 6,
  parameter int GROUP_SIZE  = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [tmf_pkg::CH_BITS-1:0]       channel,
  input  wire logic [tmf_pkg::SAMPLE_IN_W-1:0]   sample,
  output logic                                   busy,
  output logic                                   done,
  output logic      [tmf_pkg::CH_BITS-1:0]       result_channel,
  output logic      [tmf_pkg::OUT_BITS-1:0]      filtered
);

  localparam int DEPTH = CHANNELS * GROUP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(GROUP_SIZE);
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = SAMPLE_BITS + tmf_pkg::SUM_GROWTH;
  // Division by three is a multiply by a rounded-up reciprocal. With two
  // fraction bits beyond the sum's width the truncated quotient is exact.
  localparam int SHIFT = SUM_W + 2;
  localparam int RW    = SHIFT - 1;
  localparam logic [RW-1:0] RECIP =
    RW'((2**SHIFT + tmf_pkg::KEEP_COUNT - 1) / tmf_pkg::KEEP_COUNT);
  localparam logic [FW-1:0] POS_LAST = FW'(GROUP_SIZE - 1);

  logic                   accept;
  logic                   ch_ok;
  logic [CIW-1:0]         ch_idx;
  logic [FW-1:0]          fill_count [CHANNELS];
  logic [FW-1:0]          pos;
  logic                   group_full;
  logic                   store_we;
  logic [AW-1:0]          waddr;
  logic [SAMPLE_BITS-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   rank_start;
  logic [AW-1:0]          base;
  logic                   rank_done;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W+RW-1:0]    product;
  logic [tmf_pkg::CH_BITS-1:0] pend_channel;

  // A request is taken whenever the sequencer is free. A channel number past
  // the last channel is taken and dropped without touching any state.
  assign accept = start && !busy;
  assign ch_ok  = (32'(channel) < CHANNELS);
  assign ch_idx = CIW'(channel);
  assign pos    = fill_count[ch_idx];
  assign group_full = (pos == POS_LAST);

  assign store_we   = accept && ch_ok;
  assign waddr      = AW'(int'(ch_idx) * GROUP_SIZE + int'(pos));
  assign wdata      = SAMPLE_BITS'(sample);
  assign rank_start = store_we && group_full;
  assign base       = AW'(int'(ch_idx) * GROUP_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fill_count[c] <= '0;
      end
    end else if (store_we) begin
      if (group_full) begin
        fill_count[ch_idx] <= '0;
      end else begin
        fill_count[ch_idx] <= pos + FW'(1);
      end
    end
  end

  // Busy covers the whole load-and-rank pass of a completed group and drops
  // on the edge that registers the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= rank_done;
      if (rank_start) begin
        busy <= 1'b1;
      end else if (rank_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rank_start) begin
      pend_channel <= channel;
    end
    if (rank_done) begin
      result_channel <= pend_channel;
      filtered       <= tmf_pkg::OUT_BITS'(product[SUM_W+RW-1:SHIFT]);
    end
  end

  assign product = (SUM_W+RW)'(sum) * (SUM_W+RW)'(RECIP);

  tmf_store #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmf_rank #(
    .GROUP_SIZE  (GROUP_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_W      (AW)
  ) u_rank (
    .clk   (clk),
    .rst   (rst),
    .start (rank_start),
    .base  (base),
    .raddr (raddr),
    .rdata (rdata),
    .done  (rank_done),
    .sum   (sum)
  );

endmodule

`default_nettype wire

// ===== sv/tmf_store.sv =====
// ============================================================================
// tmf_store: sample memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module tmf_store #(
  parameter int DEPTH = 30,
  parameter int WIDTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/tmf_rank.sv =====
// ============================================================================
// tmf_rank: rank-and-sum sequencer
// Loads one group from the sample memory into a rotating register line, then
// ranks each sample with a single comparator and adds up the middle ones.
// ============================================================================
`default_nettype none

module tmf_rank #(
  parameter int GROUP_SIZE  = 5,
  parameter int SAMPLE_BITS = 10,
  parameter int ADDR_W      = 5
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [ADDR_W-1:0]                      base,
  output logic      [ADDR_W-1:0]                      raddr,
  input  wire logic [SAMPLE_BITS-1:0]                 rdata,
  output logic                                        done,
  output logic      [SAMPLE_BITS+tmf_pkg::SUM_GROWTH-1:0] sum
);

  localparam int FW     = $clog2(GROUP_SIZE);
  localparam int GW     = $clog2(GROUP_SIZE + 1);
  localparam int SUM_W  = SAMPLE_BITS + tmf_pkg::SUM_GROWTH;
  localparam int MID    = GROUP_SIZE / 2;
  localparam int HALF   = tmf_pkg::KEEP_COUNT / 2;
  localparam logic [FW-1:0] RANK_LO = FW'(MID - HALF);
  localparam logic [FW-1:0] RANK_HI = FW'(MID + HALF);
  localparam logic [GW-1:0] G_CNT   = GW'(GROUP_SIZE);
  localparam logic [FW-1:0] J_LAST  = FW'(GROUP_SIZE - 1);

  tmf_pkg::tmf_state_t state, state_next;

  logic [ADDR_W-1:0]      base_q;
  logic [GW-1:0]          cnt;
  logic                   rd_valid;
  logic [FW-1:0]          j;
  logic [GW-1:0]          s;
  logic [SAMPLE_BITS-1:0] work [GROUP_SIZE];
  logic [SAMPLE_BITS-1:0] cand;
  logic [FW-1:0]          rank;
  logic [FW-1:0]          kidx;
  logic                   issue_rd;
  logic                   load_end;
  logic                   round_end;
  logic                   finish;
  logic                   counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    int kt;
    state_next = state;
    issue_rd   = 1'b0;
    load_end   = 1'b0;
    round_end  = 1'b0;
    finish     = 1'b0;
    kt = int'(j) + int'(s);
    if (kt >= GROUP_SIZE) begin
      kt = kt - GROUP_SIZE;
    end
    kidx = FW'(kt);
    case (state)
      tmf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tmf_pkg::ST_LOAD;
        end
      end
      tmf_pkg::ST_LOAD: begin
        issue_rd = (cnt < G_CNT);
        load_end = (cnt == G_CNT);
        if (load_end) begin
          state_next = tmf_pkg::ST_RANK;
        end
      end
      tmf_pkg::ST_RANK: begin
        round_end = (s == G_CNT);
        finish    = round_end && (j == J_LAST);
        if (finish) begin
          state_next = tmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmf_pkg::ST_IDLE;
      end
    endcase
  end

  // The one comparator: a sample ranks behind every larger one and behind an
  // equal one that sits earlier in the group.
  assign counts = (work[0] > cand) || ((work[0] == cand) && (kidx < j));

  assign raddr = base_q + ADDR_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= issue_rd;
      done     <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tmf_pkg::ST_IDLE) && start) begin
      base_q <= base;
      cnt    <= '0;
    end
    if (state == tmf_pkg::ST_LOAD) begin
      cnt <= cnt + GW'(1);
      if (load_end) begin
        j   <= '0;
        s   <= '0;
        sum <= '0;
      end
    end
    if (rd_valid) begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
        work[i] <= work[i + 1];
      end
      work[GROUP_SIZE - 1] <= rdata;
    end
    if (state == tmf_pkg::ST_RANK) begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
        work[i] <= work[i + 1];
      end
      work[GROUP_SIZE - 1] <= work[0];
      if (s == '0) begin
        cand <= work[0];
        rank <= '0;
      end else if (!round_end) begin
        if (counts) begin
          rank <= rank + FW'(1);
        end
      end
      if (round_end) begin
        s <= '0;
        j <= j + FW'(1);
        if (rank inside {[RANK_LO:RANK_HI]}) begin
          sum <= sum + SUM_W'(cand);
        end
      end else begin
        s <= s + GW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmf_checker.sv =====
// ============================================================================
// tmf_checker: port-level checks of the trimmed mean filter
// Watches the request and result ports and is bound to the top level.
// ============================================================================
`default_nettype none

module tmf_checker #(
  parameter int CHANNELS = 6
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic [tmf_pkg::CH_BITS-1:0]     channel,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [tmf_pkg::CH_BITS-1:0]     result_channel
);

  // A result ends a busy period and busy is already low with it.
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a busy period");

  // Two results can never come in adjacent cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Busy only starts from a taken request.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A request for a channel that does not exist starts no work.
  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (32'(channel) >= CHANNELS)) |=> !busy)
    else $error("out-of-range channel started work");

  // Results only name existing channels.
  a_result_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result_channel) < CHANNELS))
    else $error("result names a channel that does not exist");

endmodule

bind trimmed_mean_of_five_filter tmf_checker #(
  .CHANNELS (CHANNELS)
) u_tmf_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .channel        (channel),
  .busy           (busy),
  .done           (done),
  .result_channel (result_channel)
);

`default_nettype wire
